@@ hdl/tree_edit_forest_distance_table_defines.svh @@
// Assertion macros shared by the tree edit distance RTL.
`ifndef TREE_EDIT_FOREST_DISTANCE_TABLE_DEFINES_SVH
`define TREE_EDIT_FOREST_DISTANCE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define TEFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tefd assertion failed");
`define TEFD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tefd reset assertion failed");
`else
`define TEFD_ASSERT(label, prop)
`define TEFD_ASSERT_RST(label, prop)
`endif
`endif

@@ hdl/tefd_pkg.sv @@
// Constants and saturating arithmetic for the tree edit distance engine.
`default_nettype none
package tefd_pkg;
  localparam int NODE_W = 7;
  localparam int IDX_W  = NODE_W + 1;
  localparam int DIST_W = 16;
  localparam int COST_W = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [2:0] MODE_X_END  = 3'd0;
  localparam logic [2:0] MODE_Y_END  = 3'd1;
  localparam logic [2:0] MODE_X_KEY  = 3'd2;
  localparam logic [2:0] MODE_Y_KEY  = 3'd3;
  localparam logic [2:0] MODE_COST   = 3'd4;
  localparam logic [2:0] MODE_PAIR   = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;

  typedef logic [DIST_W-1:0] dist_t;

  // Returns {overflow, clipped sum}.
  function automatic logic [DIST_W:0] sat_add(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[DIST_W]) begin
      return {1'b1, DIST_MAX};
    end
    return s;
  endfunction
endpackage
`default_nettype wire

@@ hdl/tree_edit_forest_distance_table.sv @@
// Sequence: a load item sets the result valid straight from idle, a read item passes
// the read and done states, and a compute item fills an I by J table before done.
// Each interior cell steps through C0, C1 and C2 around the forest table read port.
// Throughput: one item at a time; the block is not ready until the result is taken.
// Reset clears the sequencer, the result valid and the saturate flag; stores are
// undefined until written.
`default_nettype none
`include "tree_edit_forest_distance_table_defines.svh"
module tree_edit_forest_distance_table import tefd_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // mode[2:0]
  input  wire  [2:0]  s_tuser,
  // first_index[6:0], second_index[13:7], load_value[21:14], zero pad
  input  wire  [23:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // read_distance[15:0], saturated[16], zero pad
  output logic [23:0] m_tdata
);
  localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_K0 = 4'd2, ST_K1 = 4'd3,
    ST_K2 = 4'd4, ST_BCOL = 4'd5, ST_SROW = 4'd6, ST_BROW = 4'd7, ST_CINIT = 4'd8,
    ST_C0 = 4'd9, ST_C1 = 4'd10, ST_C2 = 4'd11, ST_DONE = 4'd12;

  logic [3:0] state;
  logic [2:0] mode;
  logic [NODE_W-1:0] a_reg, b_reg;
  logic [IDX_W-1:0] i, j, i0, j0, imax, jmax;
  logic [NODE_W-1:0] xroot_end, yroot_end;
  dist_t val, colv, left, del_raw, sub_lat;
  logic match;
  logic match_c;
  logic flag;
  dist_t out_dist;

  logic [NODE_W-1:0] x_end [0:(1<<NODE_W)-1];
  logic [NODE_W-1:0] y_end [0:(1<<NODE_W)-1];
  logic [NODE_W-1:0] x_key [0:(1<<NODE_W)-1];
  logic [NODE_W-1:0] y_key [0:(1<<NODE_W)-1];
  logic [COST_W-1:0] cost_mem [0:(1<<(2*NODE_W))-1];
  dist_t td_mem [0:(1<<(2*NODE_W))-1];
  dist_t fd_mem [0:(1<<(2*IDX_W))-1];

  logic [NODE_W-1:0] rd_xe, rd_ye, rd_xk, rd_yk;
  logic [COST_W-1:0] rd_cost;
  dist_t rd_td, rd_fd;
  logic [NODE_W-1:0] xe_addr, ye_addr;
  logic [2*NODE_W-1:0] td_raddr;
  logic [2*IDX_W-1:0] fd_raddr, fd_waddr;
  dist_t fd_wdata;
  logic fd_we;

  wire accept = s_tvalid && s_tready;
  wire [2:0] in_mode = s_tuser;
  wire [NODE_W-1:0] in_a = s_tdata[6:0];
  wire [NODE_W-1:0] in_b = s_tdata[13:7];
  wire [COST_W-1:0] in_v = s_tdata[21:14];

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign m_tdata = {7'd0, flag, out_dist};

  logic [DIST_W:0] inc_val, inc_colv;
  assign inc_val  = sat_add(dist_t'(1), val);
  assign inc_colv = sat_add(dist_t'(1), colv);

  dist_t cell_v;
  logic cell_ovf;
  tefd_cell u_cell (
    .sub_a (sub_lat),
    .sub_b (rd_fd),
    .del_in(del_raw),
    .ins_in(left),
    .value (cell_v),
    .ovf   (cell_ovf)
  );

  assign match_c = (rd_xe == xroot_end) && (rd_ye == yroot_end);

  always_comb begin
    xe_addr  = (state == ST_K1) ? rd_xk : i[NODE_W-1:0];
    ye_addr  = (state == ST_K1) ? rd_yk : j[NODE_W-1:0];
    td_raddr = (state == ST_RD) ? {a_reg, b_reg} : {i[NODE_W-1:0], j[NODE_W-1:0]};
    if (state == ST_C1) begin
      fd_raddr = match_c ? {i + IDX_W'(1), j + IDX_W'(1)}
                         : {{1'b0, rd_xe} + IDX_W'(1), {1'b0, rd_ye} + IDX_W'(1)};
    end else begin
      fd_raddr = {i + IDX_W'(1), j};
    end
    fd_we = 1'b0;
    fd_waddr = {i, j};
    fd_wdata = cell_v;
    unique case (state)
      ST_K2: begin
        fd_we = 1'b1;
        fd_waddr = {{1'b0, rd_xe} + IDX_W'(1), {1'b0, rd_ye} + IDX_W'(1)};
        fd_wdata = '0;
      end
      ST_BCOL: begin
        fd_we = 1'b1;
        fd_waddr = {i, jmax};
        fd_wdata = inc_val[DIST_W-1:0];
      end
      ST_BROW: begin
        fd_we = 1'b1;
        fd_waddr = {imax, j};
        fd_wdata = inc_val[DIST_W-1:0];
      end
      ST_C2: fd_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_X_END) x_end[in_a] <= in_v[NODE_W-1:0];
    if (accept && in_mode == MODE_Y_END) y_end[in_a] <= in_v[NODE_W-1:0];
    if (accept && in_mode == MODE_X_KEY) x_key[in_a] <= in_v[NODE_W-1:0];
    if (accept && in_mode == MODE_Y_KEY) y_key[in_a] <= in_v[NODE_W-1:0];
    if (accept && in_mode == MODE_COST) cost_mem[{in_a, in_b}] <= in_v;
    if (state == ST_C2 && match) td_mem[{i[NODE_W-1:0], j[NODE_W-1:0]}] <= cell_v;
    if (fd_we) fd_mem[fd_waddr] <= fd_wdata;
    rd_xe   <= x_end[xe_addr];
    rd_ye   <= y_end[ye_addr];
    rd_xk   <= x_key[a_reg];
    rd_yk   <= y_key[b_reg];
    rd_cost <= cost_mem[{i[NODE_W-1:0], j[NODE_W-1:0]}];
    rd_td   <= td_mem[td_raddr];
    rd_fd   <= fd_mem[fd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      flag <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode <= in_mode;
            a_reg <= in_a;
            b_reg <= in_b;
            out_dist <= '0;
            if (in_mode == MODE_PAIR) begin
              state <= ST_K0;
            end else if (in_mode == MODE_READ) begin
              state <= ST_RD;
            end else begin
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_RD: state <= ST_DONE;
        ST_K0: state <= ST_K1;
        ST_K1: begin
          i0 <= {1'b0, rd_xk};
          j0 <= {1'b0, rd_yk};
          state <= ST_K2;
        end
        ST_K2: begin
          xroot_end <= rd_xe;
          yroot_end <= rd_ye;
          imax <= {1'b0, rd_xe} + IDX_W'(1);
          jmax <= {1'b0, rd_ye} + IDX_W'(1);
          i <= {1'b0, rd_xe};
          flag <= 1'b0;
          val <= '0;
          state <= ({1'b0, rd_xe} + IDX_W'(1) > i0) ? ST_BCOL : ST_SROW;
        end
        ST_BCOL: begin
          val <= inc_val[DIST_W-1:0];
          if (inc_val[DIST_W]) flag <= 1'b1;
          if (i == i0) state <= ST_SROW;
          else i <= i - IDX_W'(1);
        end
        ST_SROW: begin
          val <= '0;
          j <= jmax - IDX_W'(1);
          state <= (jmax > j0) ? ST_BROW : ST_CINIT;
        end
        ST_BROW: begin
          val <= inc_val[DIST_W-1:0];
          if (inc_val[DIST_W]) flag <= 1'b1;
          if (j == j0) state <= ST_CINIT;
          else j <= j - IDX_W'(1);
        end
        ST_CINIT: begin
          i <= imax - IDX_W'(1);
          j <= jmax - IDX_W'(1);
          colv <= dist_t'(1);
          left <= dist_t'(1);
          state <= (imax > i0 && jmax > j0) ? ST_C0 : ST_DONE;
        end
        ST_C0: state <= ST_C1;
        ST_C1: begin
          match <= match_c;
          del_raw <= rd_fd;
          sub_lat <= match_c ? dist_t'(rd_cost) : rd_td;
          state <= ST_C2;
        end
        ST_C2: begin
          if (cell_ovf) flag <= 1'b1;
          if (j == j0) begin
            if (i == i0) begin
              state <= ST_DONE;
            end else begin
              // Next row starts from its boundary column value.
              i <= i - IDX_W'(1);
              j <= jmax - IDX_W'(1);
              colv <= inc_colv[DIST_W-1:0];
              left <= inc_colv[DIST_W-1:0];
              state <= ST_C0;
            end
          end else begin
            j <= j - IDX_W'(1);
            left <= cell_v;
            state <= ST_C0;
          end
        end
        ST_DONE: begin
          if (mode == MODE_READ) out_dist <= rd_td;
          m_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TEFD_ASSERT(a_ready_no_result, s_tready |-> !m_tvalid)
  `TEFD_ASSERT(a_cell_in_range, (state == ST_C2) |-> (i >= i0 && j >= j0 && i < imax && j < jmax))
  `TEFD_ASSERT(a_busy_not_ready, (state != ST_IDLE) |-> !s_tready)
  `TEFD_ASSERT_RST(a_reset_idle, $past(rst) |-> (state == ST_IDLE && !m_tvalid && !flag))
endmodule
`default_nettype wire

@@ hdl/tefd_cell.sv @@
// Shared cell unit: three saturating sums and their minimum.
`default_nettype none
module tefd_cell import tefd_pkg::*; (
  input  wire dist_t sub_a,
  input  wire dist_t sub_b,
  input  wire dist_t del_in,
  input  wire dist_t ins_in,
  output dist_t      value,
  output logic       ovf
);
  logic [DIST_W:0] s_sub, s_del, s_ins;
  dist_t m;
  always_comb begin
    s_sub = sat_add(sub_a, sub_b);
    s_del = sat_add(dist_t'(1), del_in);
    s_ins = sat_add(dist_t'(1), ins_in);
    m = (s_sub[DIST_W-1:0] < s_del[DIST_W-1:0]) ? s_sub[DIST_W-1:0] : s_del[DIST_W-1:0];
    value = (m < s_ins[DIST_W-1:0]) ? m : s_ins[DIST_W-1:0];
    ovf = s_sub[DIST_W] | s_del[DIST_W] | s_ins[DIST_W];
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the tree edit distance engine with a built-in prediction model.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tefd_pkg::*;

  localparam int NODES = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] MODE_NONE = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [2:0]  s_tuser;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  tree_edit_forest_distance_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predicted engine state.
  logic [NODE_W-1:0] x_end [NODES];
  logic [NODE_W-1:0] y_end [NODES];
  logic [NODE_W-1:0] x_key [NODES];
  logic [NODE_W-1:0] y_key [NODES];
  logic [COST_W-1:0] relabel [NODES][NODES];
  dist_t             forest [NODES+1][NODES+1];
  dist_t             tree_dist [NODES][NODES];
  bit                tree_dist_valid [NODES][NODES];
  logic              sat_flag;

  typedef struct packed {
    dist_t distance;
    logic  saturated;
  } outcome_t;

  outcome_t pending_outcomes[$];
  int mismatch_count;
  int cycle_count;
  int burst_left;

  // Generated tree shapes, node numbers relative to the tree's base.
  int shape_x [8];
  int shape_y [8];

  function automatic dist_t add_clip(input dist_t a, input dist_t b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[DIST_W]) begin
      sat_flag = 1'b1;
      return DIST_MAX;
    end
    return s[DIST_W-1:0];
  endfunction

  function automatic dist_t min_of3(input dist_t a, input dist_t b, input dist_t c);
    dist_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic void fill_pair_table(input int k, input int l);
    int i0, j0, imax, jmax, i, j, a, b;
    dist_t del, ins, rel, sub, v;
    i0 = x_key[k];
    j0 = y_key[l];
    imax = x_end[i0] + 1;
    jmax = y_end[j0] + 1;
    sat_flag = 1'b0;
    forest[imax][jmax] = '0;
    for (i = imax - 1; i >= i0; i--)
      forest[i][jmax] = add_clip(dist_t'(1), forest[i+1][jmax]);
    for (j = jmax - 1; j >= j0; j--)
      forest[imax][j] = add_clip(dist_t'(1), forest[imax][j+1]);
    for (i = imax - 1; i >= i0; i--) begin
      for (j = jmax - 1; j >= j0; j--) begin
        del = add_clip(dist_t'(1), forest[i+1][j]);
        ins = add_clip(dist_t'(1), forest[i][j+1]);
        if (x_end[i] == x_end[i0] && y_end[j] == y_end[j0]) begin
          rel = add_clip(dist_t'(relabel[i][j]), forest[i+1][j+1]);
          v = min_of3(rel, del, ins);
          tree_dist[i][j] = v;
          tree_dist_valid[i][j] = 1'b1;
        end else begin
          a = x_end[i] + 1;
          b = y_end[j] + 1;
          sub = add_clip(tree_dist[i][j], forest[a][b]);
          v = min_of3(sub, del, ins);
        end
        forest[i][j] = v;
      end
    end
  endfunction

  function automatic outcome_t predict_outcome(input logic [2:0] mode, input int a, input int b,
                                               input int v);
    outcome_t o;
    o.distance = '0;
    case (mode)
      MODE_X_END: x_end[a] = v[NODE_W-1:0];
      MODE_Y_END: y_end[a] = v[NODE_W-1:0];
      MODE_X_KEY: x_key[a] = v[NODE_W-1:0];
      MODE_Y_KEY: y_key[a] = v[NODE_W-1:0];
      MODE_COST:  relabel[a][b] = v[COST_W-1:0];
      MODE_PAIR:  fill_pair_table(a, b);
      MODE_READ:  o.distance = tree_dist[a][b];
      default: ;
    endcase
    o.saturated = sat_flag;
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls in its own rhythm: long ready stretches, then random stalls.
  int stall_phase;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[6]) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    outcome_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tree_edit_forest_distance_table] ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tdata[15:0] !== want.distance || m_tdata[16] !== want.saturated
            || m_tdata[23:17] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected distance %0d sat %0d, got distance %0d sat %0d",
                     want.distance, want.saturated, m_tdata[15:0], m_tdata[16]);
        end
      end
    end
  end

  task automatic send_request(input logic [2:0] mode, input int a, input int b, input int v);
    int gap;
    outcome_t expected;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b0, v[7:0], b[6:0], a[6:0]};
    do @(posedge clk); while (!s_tready);
    expected = predict_outcome(mode, a % NODES, b % NODES, v);
    pending_outcomes = {pending_outcomes, expected};
  endtask

  task automatic drain_outcomes();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Random tree of n nodes in preorder; shape holds each node's subtree end.
  task automatic build_shape(input int n, output int shape [8]);
    int parent [8];
    int path [$];
    int t, p, pops;
    path = {0};
    parent[0] = -1;
    for (t = 0; t < n; t++) shape[t] = t;
    for (t = 1; t < n; t++) begin
      pops = $urandom_range(0, path.size() - 1);
      repeat (pops) void'(path.pop_back());
      parent[t] = path[$];
      path = {path, t};
      p = parent[t];
      while (p >= 0) begin
        if (shape[p] < t) shape[p] = t;
        p = parent[p];
      end
    end
  endtask

  // Loads two trees, computes every keyroot pair in dependency order, reads distances back.
  task automatic run_tree_pair(input int nx, input int ny, input bit wide_costs);
    int xb, yb, i, j, v;
    build_shape(nx, shape_x);
    build_shape(ny, shape_y);
    xb = $urandom_range(0, NODES - nx);
    yb = $urandom_range(0, NODES - ny);
    for (i = 0; i < nx; i++) begin
      v = xb + shape_x[i] + ($urandom_range(0, 1) ? 128 : 0);
      send_request(MODE_X_END, xb + i, $urandom_range(0, 127), v);
      send_request(MODE_X_KEY, i, $urandom_range(0, 127), xb + i);
    end
    for (j = 0; j < ny; j++) begin
      v = yb + shape_y[j] + ($urandom_range(0, 1) ? 128 : 0);
      send_request(MODE_Y_END, yb + j, $urandom_range(0, 127), v);
      send_request(MODE_Y_KEY, j, $urandom_range(0, 127), yb + j);
    end
    for (i = 0; i < nx; i++)
      for (j = 0; j < ny; j++)
        send_request(MODE_COST, xb + i, yb + j,
                     wide_costs ? $urandom_range(0, 255) : $urandom_range(0, 2));
    for (i = nx - 1; i >= 0; i--)
      for (j = ny - 1; j >= 0; j--)
        send_request(MODE_PAIR, i, j, $urandom_range(0, 255));
    for (i = 0; i < nx; i++)
      send_request(MODE_READ, xb + i, yb + $urandom_range(0, ny - 1), $urandom_range(0, 255));
  endtask

  task automatic test_directed();
    send_request(MODE_NONE, 127, 127, 255);
    send_request(MODE_NONE, 0, 0, 0);
    // Keyroot whose subtree end lies before it: only the corner cell is written.
    send_request(MODE_X_END, 5, 0, 3);
    send_request(MODE_Y_END, 127, 0, 130);
    send_request(MODE_X_KEY, 127, 0, 5);
    send_request(MODE_Y_KEY, 0, 0, 255);
    send_request(MODE_PAIR, 127, 0, 0);
    // Single-node trees at both ends of the node range with the largest cost.
    send_request(MODE_X_END, 127, 0, 255);
    send_request(MODE_Y_END, 0, 0, 128);
    send_request(MODE_X_KEY, 0, 0, 127);
    send_request(MODE_Y_KEY, 1, 0, 0);
    send_request(MODE_COST, 127, 0, 255);
    send_request(MODE_PAIR, 0, 1, 0);
    send_request(MODE_READ, 127, 0, 0);
    send_request(MODE_COST, 127, 0, 0);
    send_request(MODE_PAIR, 0, 1, 0);
    send_request(MODE_READ, 127, 0, 0);
  endtask

  task automatic test_random_trees();
    run_tree_pair(4, 3, 1'b1);
    drain_outcomes();
    run_tree_pair($urandom_range(2, 3), $urandom_range(2, 3), 1'b0);
  endtask

  // Stray loads, unused mode and reads of entries already computed.
  task automatic test_noise();
    int n, a, b;
    for (n = 0; n < 20; n++) begin
      a = $urandom_range(0, 127);
      b = $urandom_range(0, 127);
      case ($urandom_range(0, 3))
        0: send_request(MODE_NONE, a, b, $urandom_range(0, 255));
        1: send_request(MODE_COST, a, b, $urandom_range(0, 255));
        default: begin
          if (tree_dist_valid[a][b]) send_request(MODE_READ, a, b, $urandom_range(0, 255));
          else send_request(MODE_NONE, a, b, 0);
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    burst_left = 0;
    sat_flag = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_trees();
    test_noise();
    drain_outcomes();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("[tree_edit_forest_distance_table] OK");
    end else begin
      $display("[tree_edit_forest_distance_table] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
